@@ rtl/assert_macros.svh @@
// Assertion helpers, included by the serializer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define JSU_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define JSU_ASSERT(lbl, prop, msg) \
  `JSU_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

  // Most results that one input byte can cause (a four-byte UTF-8 sequence).
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // The results caused by one input byte, handed from decoder to serializer.
  typedef struct packed {
    logic [CntW-1:0]         cnt;
    logic [MaxRes-1:0][7:0]  bytes;
    kind_e [MaxRes-1:0]      kinds;
  } group_t;

endpackage

@@ rtl/jsu_in_if.sv @@
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

@@ rtl/jsu_out_if.sv @@
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;

  modport source (output valid, output out_byte, output kind, output run_last, input ready);
  modport sink   (input valid, input out_byte, input kind, input run_last, output ready);
endinterface

@@ rtl/json_string_unescape_utf8.sv @@
// A byte's first result is presented in the cycle after its acceptance. While the
// output is ready, bytes are taken one per cycle if each causes at most one result
// and the single result register drains one per cycle; a byte that causes n
// results (a \u escape giving n UTF-8 bytes) holds the input until all have left.
// Reset (rst_ni, asynchronous, active low) empties the result register and
// returns the decoder to waiting for an opening quote.
module json_string_unescape_utf8 (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // The decoder owns the string state and turns each accepted request into a
  // group of up to four results in one pass of combinational logic.
  logic   load;
  logic   space;
  group_t grp;

  jsu_decoder u_decoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .load_o  (load),
    .grp_o   (grp)
  );

  // The serializer registers the group and hands its results out one at a
  // time, marking the last of each group with run_last.  It frees up in the
  // same cycle that the last result is taken, so requests follow back to back.
  jsu_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .grp_i   (grp),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

@@ rtl/jsu_decoder.sv @@
module jsu_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsu_in_if.sink         in_i,
  input  logic           space_i,
  output logic           load_o,
  output jsu_pkg::group_t grp_o
);
  import jsu_pkg::*;

  typedef enum logic [7:0] {
    M_OPEN = 8'b0000_0001,
    M_BODY = 8'b0000_0010,
    M_ESC  = 8'b0000_0100,
    M_HEX1 = 8'b0000_1000,
    M_BSL  = 8'b0001_0000,
    M_LETU = 8'b0010_0000,
    M_HEX2 = 8'b0100_0000,
    M_SKIP = 8'b1000_0000
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU     = 8'h75;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic group_t utf8(input logic [20:0] cp);
    group_t g;
    g = '0;
    if (cp[20:7] == '0) begin
      g.cnt      = CntW'(1);
      g.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp[20:11] == '0) begin
      g.cnt      = CntW'(2);
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      g.cnt      = CntW'(3);
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      g.cnt      = CntW'(4);
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

  mode_e       mode_q, mode_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;

  logic        accept;
  logic [7:0]  c;
  logic        last;
  logic [4:0]  nib;
  logic [15:0] acc_new;
  logic        err, done, emit1, emitu;
  logic [7:0]  b1;
  logic [20:0] cp;

  assign accept     = in_i.valid & space_i;
  assign in_i.ready = space_i;
  assign load_o     = accept;
  assign c          = in_i.data_byte;
  assign last       = in_i.string_end;
  assign nib        = nibble(c);
  assign acc_new    = {acc_q[11:0], nib[3:0]};

  always_comb begin
    mode_d = mode_q;
    hcnt_d = hcnt_q;
    acc_d  = acc_q;
    hs_d   = hs_q;
    err    = 1'b0;
    done   = 1'b0;
    emit1  = 1'b0;
    emitu  = 1'b0;
    b1     = c;
    cp     = '0;
    case (mode_q)
      M_OPEN: begin
        if (last || c != ChQuote) begin
          err = 1'b1;
        end else begin
          mode_d = M_BODY;
        end
      end
      M_BODY: begin
        if (last) begin
          if (c == ChQuote) begin
            done   = 1'b1;
            mode_d = M_OPEN;
          end else begin
            err = 1'b1;
          end
        end else if (c == ChBsl) begin
          mode_d = M_ESC;
        end else if (c < 8'h20) begin
          err = 1'b1;
        end else begin
          emit1 = 1'b1;
        end
      end
      M_ESC: begin
        if (last) begin
          err = 1'b1;
        end else begin
          mode_d = M_BODY;
          case (c)
            ChQuote, ChBsl, ChSlash: emit1 = 1'b1;
            8'h62: begin emit1 = 1'b1; b1 = 8'h08; end
            8'h66: begin emit1 = 1'b1; b1 = 8'h0C; end
            8'h6E: begin emit1 = 1'b1; b1 = 8'h0A; end
            8'h72: begin emit1 = 1'b1; b1 = 8'h0D; end
            8'h74: begin emit1 = 1'b1; b1 = 8'h09; end
            ChU: begin
              mode_d = M_HEX1;
              hcnt_d = '0;
              acc_d  = '0;
            end
            default: err = 1'b1;
          endcase
        end
      end
      M_HEX1, M_HEX2: begin
        if (last || !nib[4]) begin
          err = 1'b1;
        end else begin
          acc_d = acc_new;
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
          end else begin
            hcnt_d = '0;
            if (mode_q == M_HEX1) begin
              if (acc_new[15:10] == 6'b110110) begin
                // High surrogate: the low half must follow as a second escape.
                hs_d   = acc_new[9:0];
                mode_d = M_BSL;
              end else if (acc_new[15:10] == 6'b110111) begin
                err = 1'b1;
              end else begin
                mode_d = M_BODY;
                emitu  = 1'b1;
                cp     = {5'b0, acc_new};
              end
            end else begin
              if (acc_new[15:10] != 6'b110111) begin
                err = 1'b1;
              end else begin
                mode_d = M_BODY;
                emitu  = 1'b1;
                cp     = {1'b0, hs_q, acc_new[9:0]} + 21'h10000;
              end
            end
          end
        end
      end
      M_BSL: begin
        if (last || c != ChBsl) begin
          err = 1'b1;
        end else begin
          mode_d = M_LETU;
        end
      end
      M_LETU: begin
        if (last || c != ChU) begin
          err = 1'b1;
        end else begin
          mode_d = M_HEX2;
          hcnt_d = '0;
          acc_d  = '0;
        end
      end
      default: begin
        mode_d = last ? M_OPEN : M_SKIP;
      end
    endcase
    if (err) begin
      mode_d = last ? M_OPEN : M_SKIP;
    end
  end

  always_comb begin
    grp_o = '0;
    if (err) begin
      grp_o.cnt      = CntW'(1);
      grp_o.kinds[0] = KIND_ERROR;
    end else if (done) begin
      grp_o.cnt      = CntW'(1);
      grp_o.kinds[0] = KIND_DONE;
    end else if (emit1) begin
      grp_o.cnt      = CntW'(1);
      grp_o.bytes[0] = b1;
    end else if (emitu) begin
      grp_o = utf8(cp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_OPEN;
      hcnt_q <= '0;
      acc_q  <= '0;
      hs_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

endmodule

@@ rtl/jsu_serializer.sv @@
`include "assert_macros.svh"

module jsu_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jsu_pkg::group_t grp_i,
  output logic            space_o,
  jsu_out_if.source       out_o
);
  import jsu_pkg::*;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [MaxRes-1:0][7:0] bytes_q;
  kind_e [MaxRes-1:0]     kinds_q;
  logic                   is_last;
  logic                   take;

  assign is_last        = (CntW'(idx_q) == cnt_q - CntW'(1));
  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = bytes_q[idx_q];
  assign out_o.kind     = kinds_q[idx_q];
  assign out_o.run_last = is_last;
  assign take           = out_o.valid & out_o.ready;
  // A new group may enter when the register is empty or its last result leaves now.
  assign space_o        = (cnt_q == '0) | (take & is_last);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (take) begin
      if (is_last) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (load_i) begin
      cnt_d = grp_i.cnt;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
      kinds_q <= grp_i.kinds;
    end
  end

  `JSU_ASSERT(a_load_only_when_free, load_i && out_o.valid |-> out_o.ready && out_o.run_last, "group loaded over pending results")
  `JSU_ASSERT(a_status_is_last, out_o.valid && out_o.kind != KIND_DATA |-> out_o.run_last && out_o.out_byte == 8'h00, "status result not alone")
  `JSU_ASSERT(a_drain_empties, take && is_last && !load_i |=> !out_o.valid, "results remain after last one taken")
  `JSU_ASSERT(a_index_in_range, out_o.valid |-> CntW'(idx_q) < cnt_q, "result index past group size")

endmodule

@@ verif/json_string_unescape_utf8_tb.sv @@
`timescale 1ns / 1ps

// Testbench for json_string_unescape_utf8.
//
// Quoted JSON string literals are pushed into the decoder one byte per request.
// A behavioral decoder inside this module tracks the same decode state and builds
// the UTF-8 bytes, done markers and error markers that each accepted byte should
// produce. A separate process compares every result request against the oldest
// prediction. Both handshakes idle at random, and one phase holds the result side
// off for a long stretch so that the single result register fills and the input
// side stalls.
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  // Characters that the decoder treats specially.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Decode states of the behavioral decoder.
  typedef enum logic [3:0] {
    ST_OPEN,
    ST_BODY,
    ST_ESC,
    ST_HEX1,
    ST_BSL,
    ST_LETU,
    ST_HEX2,
    ST_SKIP
  } dec_state_e;

  // Kinds of fault that a random string can carry.
  typedef enum int {
    FLT_CTRL,
    FLT_BAD_ESC,
    FLT_BAD_HEX,
    FLT_LONE_LOW,
    FLT_HIGH_NO_BSL,
    FLT_HIGH_NO_U,
    FLT_HIGH_NOT_LOW,
    FLT_TRUNCATE,
    FLT_NO_OPEN,
    FLT_BAD_CLOSE
  } fault_e;

  typedef struct {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       run_last;
  } result_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_utf8 uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral decoder state, kept in step with the accepted input requests.
  dec_state_e  dec_state  = ST_OPEN;
  logic [1:0]  hex_taken  = 2'd0;
  logic [15:0] code_value = 16'd0;
  logic [9:0]  high_bits  = 10'd0;

  // Results of the byte being decoded, and all results still awaited from the block.
  result_t step_out[$];
  result_t expected_out[$];

  int errors     = 0;
  int sent_count = 0;

  // Idle controls shared by the stimulus tasks and the result side.
  bit src_idle    = 1'b1;
  bit snk_idle    = 1'b1;
  int hold_cycles = 0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // Adds one byte at the tail of a string under construction.
  function automatic void append_byte(ref byte_q_t s, input logic [7:0] b);
    s = {s, b};
  endfunction

  function automatic void add_result(input logic [7:0] b, input kind_e k);
    result_t r;
    r.out_byte = b;
    r.kind     = k;
    r.run_last = 1'b0;
    step_out   = {step_out, r};
  endfunction

  function automatic void add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(cp[7:0], KIND_DATA);
    end else if (cp <= 21'h7FF) begin
      add_result(8'hC0 | cp[10:6], KIND_DATA);
      add_result(8'h80 | cp[5:0], KIND_DATA);
    end else if (cp <= 21'hFFFF) begin
      add_result(8'hE0 | cp[15:12], KIND_DATA);
      add_result(8'h80 | cp[11:6], KIND_DATA);
      add_result(8'h80 | cp[5:0], KIND_DATA);
    end else begin
      add_result(8'hF0 | cp[20:18], KIND_DATA);
      add_result(8'h80 | cp[17:12], KIND_DATA);
      add_result(8'h80 | cp[11:6], KIND_DATA);
      add_result(8'h80 | cp[5:0], KIND_DATA);
    end
  endfunction

  // A malformed string gives one error; the rest of it is skipped unless this
  // byte already closes it.
  function automatic void reject(input logic fin);
    dec_state = fin ? ST_OPEN : ST_SKIP;
    add_result(8'h00, KIND_ERROR);
  endfunction

  // Advances the behavioral decoder by one accepted byte and queues its results.
  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    int d;
    step_out.delete();
    case (dec_state)
      ST_OPEN: begin
        if (fin || c != CH_QUOTE) reject(fin);
        else dec_state = ST_BODY;
      end
      ST_BODY: begin
        if (fin) begin
          if (c == CH_QUOTE) begin
            dec_state = ST_OPEN;
            add_result(8'h00, KIND_DONE);
          end else begin
            reject(fin);
          end
        end else if (c == CH_BSL) begin
          dec_state = ST_ESC;
        end else if (c < CH_SPACE) begin
          reject(fin);
        end else begin
          add_result(c, KIND_DATA);
        end
      end
      ST_ESC: begin
        if (fin) begin
          reject(fin);
        end else begin
          dec_state = ST_BODY;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: add_result(c, KIND_DATA);
            CH_B: add_result(8'h08, KIND_DATA);
            CH_F: add_result(8'h0C, KIND_DATA);
            CH_N: add_result(8'h0A, KIND_DATA);
            CH_R: add_result(8'h0D, KIND_DATA);
            CH_T: add_result(8'h09, KIND_DATA);
            CH_U: begin
              dec_state  = ST_HEX1;
              hex_taken  = 2'd0;
              code_value = 16'd0;
            end
            default: reject(fin);
          endcase
        end
      end
      ST_HEX1, ST_HEX2: begin
        d = hex_value(c);
        if (fin || d < 0) begin
          reject(fin);
        end else begin
          code_value = {code_value[11:0], d[3:0]};
          if (hex_taken < 2'd3) begin
            hex_taken = hex_taken + 2'd1;
          end else begin
            hex_taken = 2'd0;
            if (dec_state == ST_HEX1) begin
              if (code_value >= 16'hD800 && code_value <= 16'hDBFF) begin
                high_bits = code_value[9:0];
                dec_state = ST_BSL;
              end else if (code_value >= 16'hDC00 && code_value <= 16'hDFFF) begin
                reject(fin);
              end else begin
                dec_state = ST_BODY;
                add_code_point({5'd0, code_value});
              end
            end else if (code_value < 16'hDC00 || code_value > 16'hDFFF) begin
              reject(fin);
            end else begin
              // Surrogate pair: ten bits from each half above 0x10000.
              dec_state = ST_BODY;
              add_code_point(21'h10000 + {1'b0, high_bits, 10'd0} +
                             {11'd0, code_value[9:0]});
            end
          end
        end
      end
      ST_BSL: begin
        if (fin || c != CH_BSL) reject(fin);
        else dec_state = ST_LETU;
      end
      ST_LETU: begin
        if (fin || c != CH_U) begin
          reject(fin);
        end else begin
          dec_state  = ST_HEX2;
          hex_taken  = 2'd0;
          code_value = 16'd0;
        end
      end
      default: begin
        dec_state = fin ? ST_OPEN : ST_SKIP;
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    expected_out = {expected_out, step_out};
  endfunction

  // Offers one input request, waiting a random number of cycles first when the
  // source side idles. Valid is only lowered when a gap is actually taken, so a
  // back-to-back request never sees valid dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.string_end <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, fin);
    sent_count++;
  endtask

  task automatic send_string(input byte_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
  endtask

  // Stops offering requests until every predicted result has been taken.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_esc_u(ref byte_q_t s, input logic [15:0] v);
    append_byte(s, CH_BSL);
    append_byte(s, CH_U);
    for (int i = 3; i >= 0; i--) append_byte(s, hex_char(v[i*4 +: 4], $urandom_range(0, 1)));
  endfunction

  function automatic logic [7:0] simple_letter(input int idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    for (int i = 0; i < 8; i++) if (c == simple_letter(i)) return 1'b1;
    return c == CH_U;
  endfunction

  // Basic-plane code point outside the surrogate range, spread over the
  // one-, two- and three-byte UTF-8 forms.
  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = $urandom_range(0, 16'h7F);
      1: v = $urandom_range(16'h80, 16'h7FF);
      default: begin
        v = $urandom_range(16'h800, 16'hFFFF);
        if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hD800 + $urandom_range(0, 16'h3FF);
  endfunction

  // Appends the bytes of one fault that sits inside the string body.
  function automatic void add_fault(ref byte_q_t s, input fault_e f);
    logic [7:0]  b;
    logic [15:0] v;
    case (f)
      FLT_CTRL: append_byte(s, 8'($urandom_range(0, 8'h1F)));
      FLT_BAD_ESC: begin
        b = $urandom_range(0, 255);
        while (is_escape_letter(b)) b = $urandom_range(0, 255);
        append_byte(s, CH_BSL);
        append_byte(s, b);
      end
      FLT_BAD_HEX: begin
        append_byte(s, CH_BSL);
        append_byte(s, CH_U);
        repeat ($urandom_range(0, 3)) append_byte(s, hex_char($urandom_range(0, 15), 1'b0));
        b = $urandom_range(0, 255);
        while (hex_value(b) >= 0) b = $urandom_range(0, 255);
        append_byte(s, b);
      end
      FLT_LONE_LOW: add_esc_u(s, 16'hDC00 + $urandom_range(0, 16'h3FF));
      FLT_HIGH_NO_BSL: begin
        add_esc_u(s, rand_high());
        b = $urandom_range(0, 255);
        if (b == CH_BSL) b = CH_N;
        append_byte(s, b);
      end
      FLT_HIGH_NO_U: begin
        add_esc_u(s, rand_high());
        append_byte(s, CH_BSL);
        b = $urandom_range(0, 255);
        if (b == CH_U) b = CH_N;
        append_byte(s, b);
      end
      default: begin
        // Second half of a pair that is not a low surrogate.
        add_esc_u(s, rand_high());
        v = $urandom_range(0, 16'hFFFF);
        if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h0400;
        add_esc_u(s, v);
      end
    endcase
  endfunction

  // Builds a quoted string with random content. A broken string carries one
  // fault somewhere in its body, or is cut short, or has a bad first or last byte.
  function automatic byte_q_t make_string(input bit broken);
    byte_q_t    s;
    int         n_elem;
    int         fault_at;
    fault_e     f;
    logic [7:0] b;
    logic [15:0] hi;
    append_byte(s, CH_QUOTE);
    n_elem   = $urandom_range(0, 6);
    fault_at = $urandom_range(0, n_elem);
    f        = fault_e'($urandom_range(0, 9));
    for (int k = 0; k <= n_elem; k++) begin
      if (broken && f <= FLT_HIGH_NOT_LOW && k == fault_at) add_fault(s, f);
      if (k < n_elem) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            b = $urandom_range(CH_SPACE, 8'hFF);
            if (b == CH_BSL) b = CH_QUOTE;
            append_byte(s, b);
          end
          4: begin
            append_byte(s, CH_BSL);
            append_byte(s, simple_letter($urandom_range(0, 7)));
          end
          5, 6, 7: add_esc_u(s, rand_bmp());
          8: begin
            hi = rand_high();
            add_esc_u(s, hi);
            add_esc_u(s, 16'hDC00 + $urandom_range(0, 16'h3FF));
          end
          default: append_byte(s, CH_QUOTE);
        endcase
      end
    end
    append_byte(s, CH_QUOTE);
    if (broken) begin
      case (f)
        FLT_TRUNCATE: begin
          n_elem = $urandom_range(1, s.size());
          while (s.size() > n_elem) void'(s.pop_back());
        end
        FLT_NO_OPEN: begin
          b = $urandom_range(0, 255);
          if (b == CH_QUOTE) b = 8'h41;
          s[0] = b;
        end
        FLT_BAD_CLOSE: s[s.size() - 1] = $urandom_range(0, 255);
        default: ;
      endcase
    end
    return s;
  endfunction

  // Plain bytes at the edges of the accepted range, an unescaped quote inside
  // the body, the empty string, and every simple escape.
  task automatic test_plain_text();
    send_text("\"\"");
    send_text("\" \"\377~\200\"");
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
  endtask

  // Two-, three- and four-byte UTF-8 forms, the last from a surrogate pair, so
  // one byte gives the largest burst of results.
  task automatic test_unicode();
    send_text("\"\\u00e9\\u20AC\\uD83D\\uDE00\"");
  endtask

  // Each way a string can be malformed, one string apiece.
  task automatic test_malformed();
    send_text("\"");                    // string_end on the opening byte
    send_text("A\"");                   // missing opening quote, rest skipped
    send_text("\"ab");                  // final byte not a quote
    send_text("\"\037x\"");             // unescaped control byte
    send_text("\"\\\"");                // end right after a backslash
    send_text("\"\\u12");               // end inside the hex digits
    send_text("\"\\q\"");               // unknown escape letter
    send_text("\"\\u12G4\"");           // bad hex digit
    send_text("\"\\uDC00\"");           // low surrogate without a high one
    send_text("\"\\uD800x\"");          // high surrogate not followed by a backslash
    send_text("\"\\uD800\\n\"");        // backslash but no u after a high surrogate
    send_text("\"\\uD800\\u0041\"");    // second escape is not a low surrogate
    send_text("\"\\uDBFF\\");           // end while a surrogate pair is pending
  endtask

  // Random strings until about n_bytes requests have gone in. Most are well
  // formed, some carry a fault, a few are pure noise.
  task automatic test_random(input int n_bytes, input bit src, input bit snk);
    int      stop_at;
    int      n;
    byte_q_t s;
    src_idle = src;
    snk_idle = snk;
    stop_at  = sent_count + n_bytes;
    while (sent_count < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          n = $urandom_range(1, 6);
          s.delete();
          repeat (n) append_byte(s, 8'($urandom_range(0, 255)));
          send_string(s);
        end
        2, 3, 4, 5, 6, 7: send_string(make_string(1'b1));
        default: send_string(make_string(1'b0));
      endcase
    end
  endtask

  // Result side stalls for a long stretch while the source keeps offering
  // requests back to back; the decoder fills and must hold its input.
  task automatic test_backpressure();
    int stop_at;
    src_idle    = 1'b0;
    snk_idle    = 1'b0;
    hold_cycles = 200;
    stop_at     = sent_count + 40;
    while (sent_count < stop_at) send_string(make_string(1'b0));
    wait_drain();
  endtask

  // Result side: a random stall before each result request, and the long
  // hold-off when one is asked for. Ready stays high until a result is taken or a hold-off is asked for.
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      stall = snk_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid && hold_cycles == 0) @(posedge clk_i);
    end
  end

  // Every accepted result request is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected result: out_byte %h kind %0d run_last %0d",
               out_if.out_byte, out_if.kind, out_if.run_last);
        errors++;
      end else begin
        exp = expected_out.pop_front();
        if (out_if.out_byte !== exp.out_byte) begin
          $error("out_byte: expected %h, got %h", exp.out_byte, out_if.out_byte);
          errors++;
        end
        if (out_if.kind !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, out_if.kind);
          errors++;
        end
        if (out_if.run_last !== exp.run_last) begin
          $error("run_last: expected %0d, got %0d", exp.run_last, out_if.run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.string_end = 1'b0;
    rst_ni           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle = 1'b1;
    snk_idle = 1'b1;
    test_plain_text();
    test_unicode();
    test_malformed();
    wait_drain();

    // Random phases: both sides idling, neither, and each one alone.
    test_random(60, 1'b1, 1'b1);
    test_random(50, 1'b0, 1'b0);
    wait_drain();
    test_random(50, 1'b1, 1'b0);
    test_random(50, 1'b0, 1'b1);
    test_backpressure();

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ json_string_unescape_utf8.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_decoder.sv
rtl/jsu_serializer.sv
rtl/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_tb.sv
